[rtl/pee_pkg.sv]
// Shared types and codes for the precedence expression evaluator.
// Holds the operator codes, the control state type and the structs
// passed between the top level and the iterative multiply/divide unit.
package pee_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TERM,
        ST_WAIT,
        ST_SUM,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic div;
    } t_md_ctrl;

    typedef struct packed {
        logic done;
        logic sat;
    } t_md_stat;

    localparam int unsigned OperandBits = 32;
    localparam int unsigned ResultBits  = 32;

endpackage

[rtl/precedence_expression_evaluator_core.sv]
// Top level of the two-level precedence expression evaluator.
// Depends on pee_pkg and on pee_muldiv for products and quotients.
//
// Usage: operands stream in on the s_axis channel, one per transfer. tdata
// carries the signed fixed-point operand, tuser the operator that follows
// it (add, subtract, multiply, divide) and tlast marks the final operand,
// whose operator is ignored. Multiply and divide bind tighter than add and
// subtract; each level runs left to right. After the final operand one
// transfer leaves on m_axis: tdata holds the 32-bit result (0 after a zero
// divisor), tuser bit 0 flags a zero divisor and bit 1 any saturation.
// Timing: one operand at a time; s_axis_tready is high only between items.
// An operand that only starts a term, joins the sum or hits a zero divisor
// passes from ST_IDLE through ST_TERM to ST_SUM. One that multiplies or
// divides also waits in ST_WAIT while the shared adder in pee_muldiv works
// bit by bit through VALUE_WIDTH product or VALUE_WIDTH + FRACTION_BITS
// quotient bits. A final operand then passes through ST_EMIT.
// The result sits in an output register, so the next expression is taken
// while it waits; a stalled receiver holds only the next final result.
// Reset clears all expression state and drops the output valid.
module precedence_expression_evaluator_core
    import pee_pkg::*;
#(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] operand
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] next_op
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] result
    output logic [1:0]  o_m_axis_tuser    // [0] divide_by_zero, [1] saturated
);

    localparam int W  = VALUE_WIDTH;
    localparam int XW = (W > 32) ? W : 32;
    localparam logic [XW-1:0] VMaxX = {{(XW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [XW-1:0] VMinX = ~VMaxX;
    localparam logic [XW-1:0] RMaxX = {{(XW - 31){1'b0}}, {31{1'b1}}};
    localparam logic [XW-1:0] RMinX = ~RMaxX;

    t_state r_state, n_state;
    logic signed [W-1:0] r_v, n_v;
    t_op    r_op, n_op;
    logic   r_last, n_last;
    logic signed [W-1:0] r_sum, n_sum;
    logic   r_sum_started, n_sum_started;
    t_op    r_pend_add, n_pend_add;
    logic signed [W-1:0] r_term, n_term;
    logic   r_term_started, n_term_started;
    t_op    r_pend_mul, n_pend_mul;
    logic   r_err, n_err;
    logic   r_sat, n_sat;
    logic   r_out_valid, n_out_valid;
    logic [ResultBits-1:0] r_out_data, n_out_data;
    logic [1:0] r_out_user, n_out_user;

    logic signed [XW-1:0] w_in_x, w_sum_x;
    logic signed [W-1:0]  w_in_clamped;
    logic                 w_in_hit;
    logic [ResultBits-1:0] w_res32;
    logic                 w_res_hit;
    logic                 w_sub;
    logic [W:0]           w_addsum;
    logic signed [W-1:0]  w_sum_next;
    logic                 w_sum_ovf;
    t_md_ctrl             w_md_ctrl;
    t_md_stat             w_md_stat;
    logic signed [W-1:0]  w_md_result;

    pee_muldiv #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_md_ctrl),
        .i_a     (r_term),
        .i_b     (r_v),
        .o_stat  (w_md_stat),
        .o_result(w_md_result)
    );

    // Operand range limit for narrow value widths.
    always_comb begin
        w_in_x   = XW'(signed'(i_s_axis_tdata[OperandBits-1:0]));
        w_in_hit = 1'b0;
        if (w_in_x > signed'(VMaxX)) begin
            w_in_clamped = VMaxX[W-1:0];
            w_in_hit     = 1'b1;
        end else if (w_in_x < signed'(VMinX)) begin
            w_in_clamped = VMinX[W-1:0];
            w_in_hit     = 1'b1;
        end else begin
            w_in_clamped = w_in_x[W-1:0];
        end
    end

    // Saturating add or subtract of the finished term into the sum.
    assign w_sub     = (r_pend_add == OP_SUB);
    assign w_addsum  = {r_sum[W-1], r_sum} + ({r_term[W-1], r_term} ^ {(W + 1){w_sub}})
                       + (W + 1)'(w_sub);
    assign w_sum_ovf = w_addsum[W] != w_addsum[W-1];
    assign w_sum_next = w_sum_ovf ? (w_addsum[W] ? {1'b1, {(W - 1){1'b0}}}
                                                 : {1'b0, {(W - 1){1'b1}}})
                                  : w_addsum[W-1:0];

    // Final result limited to the 32-bit output field.
    always_comb begin
        w_sum_x   = XW'(r_sum);
        w_res_hit = 1'b0;
        if (w_sum_x > signed'(RMaxX)) begin
            w_res32   = RMaxX[ResultBits-1:0];
            w_res_hit = 1'b1;
        end else if (w_sum_x < signed'(RMinX)) begin
            w_res32   = RMinX[ResultBits-1:0];
            w_res_hit = 1'b1;
        end else begin
            w_res32 = w_sum_x[ResultBits-1:0];
        end
    end

    assign w_md_ctrl.start = (r_state == ST_TERM) && r_term_started
                             && !((r_pend_mul == OP_DIV) && (r_v == '0));
    assign w_md_ctrl.div   = (r_pend_mul == OP_DIV);

    always_comb begin
        n_state        = r_state;
        n_v            = r_v;
        n_op           = r_op;
        n_last         = r_last;
        n_sum          = r_sum;
        n_sum_started  = r_sum_started;
        n_pend_add     = r_pend_add;
        n_term         = r_term;
        n_term_started = r_term_started;
        n_pend_mul     = r_pend_mul;
        n_err          = r_err;
        n_sat          = r_sat;
        n_out_data     = r_out_data;
        n_out_user     = r_out_user;
        n_out_valid    = r_out_valid && !i_m_axis_tready;

        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_v     = w_in_clamped;
                    n_op    = t_op'(i_s_axis_tuser);
                    n_last  = i_s_axis_tlast;
                    n_sat   = r_sat | w_in_hit;
                    n_state = ST_TERM;
                end
            end
            ST_TERM: begin
                if (!r_term_started) begin
                    n_term         = r_v;
                    n_term_started = 1'b1;
                    n_state        = ST_SUM;
                end else if (w_md_ctrl.start) begin
                    n_state = ST_WAIT;
                end else begin
                    // Zero divisor: flag it and keep the term as it is.
                    n_err   = 1'b1;
                    n_state = ST_SUM;
                end
            end
            ST_WAIT: begin
                if (w_md_stat.done) begin
                    n_term  = w_md_result;
                    n_sat   = r_sat | w_md_stat.sat;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (r_last || (r_op == OP_ADD) || (r_op == OP_SUB)) begin
                    if (!r_sum_started) begin
                        n_sum = r_term;
                    end else begin
                        n_sum = w_sum_next;
                        n_sat = r_sat | w_sum_ovf;
                    end
                    n_sum_started  = 1'b1;
                    n_term_started = 1'b0;
                    if (!r_last) begin
                        n_pend_add = r_op;
                    end
                end else begin
                    n_pend_mul = r_op;
                end
                n_state = r_last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid    = 1'b1;
                    n_out_data     = r_err ? '0 : w_res32;
                    n_out_user     = {r_sat | (!r_err & w_res_hit), r_err};
                    n_sum_started  = 1'b0;
                    n_pend_add     = OP_ADD;
                    n_term_started = 1'b0;
                    n_pend_mul     = OP_MUL;
                    n_err          = 1'b0;
                    n_sat          = 1'b0;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_sum_started  <= 1'b0;
            r_pend_add     <= OP_ADD;
            r_term_started <= 1'b0;
            r_pend_mul     <= OP_MUL;
            r_err          <= 1'b0;
            r_sat          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_sum_started  <= n_sum_started;
            r_pend_add     <= n_pend_add;
            r_term_started <= n_term_started;
            r_pend_mul     <= n_pend_mul;
            r_err          <= n_err;
            r_sat          <= n_sat;
            r_out_valid    <= n_out_valid;
        end
        r_v        <= n_v;
        r_op       <= n_op;
        r_last     <= n_last;
        r_sum      <= n_sum;
        r_term     <= n_term;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

[rtl/pee_muldiv.sv]
// Iterative fixed-point multiply/divide unit of the expression evaluator.
// One shared adder/subtractor serves a shift-add multiplier and a restoring
// divider; depends on pee_pkg for the control and status structs.
module pee_muldiv
    import pee_pkg::*;
#(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_md_ctrl                      i_ctrl,
    input  logic signed [VALUE_WIDTH-1:0] i_a,
    input  logic signed [VALUE_WIDTH-1:0] i_b,
    output t_md_stat                      o_stat,
    output logic signed [VALUE_WIDTH-1:0] o_result
);

    localparam int W  = VALUE_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int NW = W + F;
    localparam int MW = (2 * W > NW) ? 2 * W : NW;
    localparam int CW = $clog2(NW);
    localparam logic [MW-1:0] LimPos = {{(MW - W + 1){1'b0}}, {(W - 1){1'b1}}};

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic          r_div, n_div;
    logic          r_neg, n_neg;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_mcand, n_mcand;
    logic [2*W-1:0] r_prod, n_prod;
    logic [W-1:0]  r_rem, n_rem;
    logic [NW-1:0] r_num, n_num;

    logic [W-1:0]  w_mag_a, w_mag_b;
    logic [W:0]    w_rem_sh;
    logic [W+1:0]  w_add_a, w_add_b, w_sum;
    logic [MW-1:0] w_mag, w_limit;
    logic          w_over;
    logic [W-1:0]  w_low;

    assign w_mag_a = i_a[W-1] ? (~i_a + W'(1)) : i_a;
    assign w_mag_b = i_b[W-1] ? (~i_b + W'(1)) : i_b;

    // Shared adder: adds the multiplicand or subtracts the divisor.
    assign w_rem_sh = {r_rem, r_num[NW-1]};
    assign w_add_a  = r_div ? {1'b0, w_rem_sh} : {2'b00, r_prod[2*W-1:W]};
    assign w_add_b  = {2'b00, r_mcand};
    assign w_sum    = w_add_a + (w_add_b ^ {(W + 2){r_div}}) + (W + 2)'(r_div);

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_div   = r_div;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_mcand = r_mcand;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_num   = r_num;
        if (i_ctrl.start) begin
            n_busy = 1'b1;
            n_div  = i_ctrl.div;
            n_neg  = i_a[W-1] ^ i_b[W-1];
            n_rem  = '0;
            if (i_ctrl.div) begin
                n_cnt   = CW'(NW - 1);
                n_mcand = w_mag_b;
                n_num   = NW'(w_mag_a) << F;
            end else begin
                n_cnt   = CW'(W - 1);
                n_mcand = w_mag_a;
                n_prod  = {{W{1'b0}}, w_mag_b};
            end
        end else if (r_busy) begin
            if (r_div) begin
                if (!w_sum[W+1]) begin
                    n_rem = w_sum[W-1:0];
                    n_num = {r_num[NW-2:0], 1'b1};
                end else begin
                    n_rem = w_rem_sh[W-1:0];
                    n_num = {r_num[NW-2:0], 1'b0};
                end
            end else if (r_prod[0]) begin
                n_prod = {w_sum[W:0], r_prod[W-1:1]};
            end else begin
                n_prod = {1'b0, r_prod[2*W-1:1]};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_div   <= n_div;
        r_neg   <= n_neg;
        r_cnt   <= n_cnt;
        r_mcand <= n_mcand;
        r_prod  <= n_prod;
        r_rem   <= n_rem;
        r_num   <= n_num;
    end

    // The magnitude is final once the unit has stopped; apply sign and range.
    assign w_mag   = r_div ? MW'(r_num) : MW'(r_prod >> F);
    assign w_limit = LimPos + MW'(r_neg);
    assign w_over  = w_mag > w_limit;
    assign w_low   = w_mag[W-1:0];

    always_comb begin
        if (w_over) begin
            o_result = r_neg ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
        end else if (r_neg) begin
            o_result = ~w_low + W'(1);
        end else begin
            o_result = w_low;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.sat  = w_over;

endmodule
